### rtl/kct_pkg.sv
// Package: command codes, status codes, error codes, controller types and channel payload types.
`default_nettype none
package kct_pkg;
	localparam logic [2:0] CMD_CLEAR = 3'd0;
	localparam logic [2:0] CMD_ADD = 3'd1;
	localparam logic [2:0] CMD_ADD_VER = 3'd2;
	localparam logic [2:0] CMD_FIND_ACT = 3'd3;
	localparam logic [2:0] CMD_FIND_ANY = 3'd4;
	localparam logic [2:0] CMD_GET_ST = 3'd5;
	localparam logic [2:0] CMD_SET_ST = 3'd6;
	localparam logic [2:0] CMD_REMOVE = 3'd7;

	localparam logic [1:0] ST_UNKNOWN = 2'd0;
	localparam logic [1:0] ST_ACTIVE = 2'd1;
	localparam logic [1:0] ST_EXPIRED = 2'd2;
	localparam logic [1:0] ST_REVOKED = 2'd3;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_MAC = 2'd1;
	localparam logic [1:0] ERR_FULL = 2'd2;
	localparam logic [1:0] ERR_EXPIRED = 2'd3;

	typedef struct packed {
		logic load;
		logic scan_start;
		logic scan_step;
		logic commit;
	} kct_cmd_t;

	typedef struct packed {
		logic scan_last;
	} kct_stat_t;

	typedef struct packed {
		logic [1:0] error_code;
		logic       found;
		logic [3:0] slot;
		logic [1:0] entry_state;
		logic [4:0] live_entries;
	} kct_res_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [63:0] key_word0;
		logic [63:0] key_word1;
		logic [63:0] key_word2;
		logic [63:0] key_word3;
		logic [63:0] valid_to;
		logic [63:0] now_secs;
		logic [1:0]  new_status;
		logic        digest_ok;
		logic        signature_ok;
	} kct_req_t;
endpackage
`default_nettype wire

### rtl/kct_if.sv
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface kct_req_if;
	import kct_pkg::*;
	logic     valid;
	logic     ready;
	kct_req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface kct_res_if;
	import kct_pkg::*;
	logic     valid;
	logic     ready;
	kct_res_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/keyed_capability_table_top.sv
// Top level: keyed capability table, controller plus scanning datapath.
// channel | dir | payload
// req     | in  | cmd, key words, times, status, check flags
// res     | out | error_code, found, slot, entry_state, live_entries
// Each beat goes through a load, a scan of every entry (one entry compared
// per cycle) and a commit. The result register lets the
// next beat load and scan while the previous result waits. Reset clears all
// entries. A result still unaccepted at commit holds the next beat in the
// commit cycle (table write included); the request side waits until idle.
`default_nettype none
module keyed_capability_table_top #(
	parameter int CAPACITY = 16,
	parameter int KEY_BITS = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	kct_req_if.sink  req,
	kct_res_if.source res
);
	import kct_pkg::*;
	kct_cmd_t  cmd;
	kct_stat_t stat;

	kct_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(res.valid), .out_ready(res.ready),
		.cmd(cmd), .stat(stat)
	);

	kct_dp #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .stat(stat),
		.req(req.data), .res(res.data)
	);
endmodule
`default_nettype wire

### rtl/kct_ctrl.sv
// Controller: accept a beat, scan the table one entry per cycle, commit, hold result.
`default_nettype none
module kct_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output kct_pkg::kct_cmd_t      cmd,
	input  wire kct_pkg::kct_stat_t stat
);
	import kct_pkg::*;
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;

	logic [1:0] state_q;
	logic out_valid_q;

	wire can_load = (state_q == S_IDLE);
	wire res_free = !out_valid_q || out_ready;
	assign in_ready = can_load;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && can_load;
		cmd.scan_start = cmd.load;
		cmd.scan_step = (state_q == S_SCAN);
		cmd.commit = (state_q == S_COMMIT) && res_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid && can_load) state_q <= S_SCAN;
				S_SCAN: if (stat.scan_last) state_q <= S_COMMIT;
				S_COMMIT: if (res_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### rtl/kct_dp.sv
// Datapath: entry store, sequential key match scan, command execution.
`default_nettype none
module kct_dp #(
	parameter int CAPACITY = 16,
	parameter int KEY_BITS = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire kct_pkg::kct_cmd_t  cmd,
	output kct_pkg::kct_stat_t      stat,
	input  wire kct_pkg::kct_req_t  req,
	output kct_pkg::kct_res_t       res
);
	import kct_pkg::*;
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic [CAPACITY-1:0] used_q;
	logic [255:0] key_q [CAPACITY];
	logic [63:0]  exp_q [CAPACITY];
	logic [1:0]   st_q  [CAPACITY];
	logic [CW-1:0] live_q;

	kct_req_t r_q;
	logic [255:0] kmask;
	logic [IW-1:0] idx_q;
	logic hit_q, free_q;
	logic [IW-1:0] hit_idx_q, free_idx_q;
	kct_res_t res_q;
	kct_res_t res_d;

	always_comb begin
		kmask = {r_q.key_word3, r_q.key_word2, r_q.key_word1, r_q.key_word0};
		for (int b = 0; b < 256; b++) if (b >= KEY_BITS) kmask[b] = 1'b0;
	end

	assign stat.scan_last = (idx_q == IW'(CAPACITY - 1));
	assign res = res_q;

	wire match = used_q[idx_q] && (key_q[idx_q] == kmask);

	logic [IW-1:0] pos;
	logic [1:0] pst;
	always_comb begin
		pos = hit_q ? hit_idx_q : free_idx_q;
		pst = st_q[hit_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			live_q <= '0;
			for (int i = 0; i < CAPACITY; i++) begin
				key_q[i] <= '0;
				exp_q[i] <= '0;
				st_q[i] <= ST_UNKNOWN;
			end
		end else if (cmd.commit) begin
			case (r_q.cmd)
				CMD_CLEAR: begin
					used_q <= '0;
					live_q <= '0;
					for (int i = 0; i < CAPACITY; i++) begin
						key_q[i] <= '0;
						exp_q[i] <= '0;
						st_q[i] <= ST_UNKNOWN;
					end
				end
				CMD_ADD, CMD_ADD_VER: begin
					if (!(r_q.cmd == CMD_ADD_VER && (r_q.valid_to <= r_q.now_secs
						|| !r_q.signature_ok)) && r_q.digest_ok && (hit_q || free_q)) begin
						if (!hit_q) live_q <= live_q + 1'b1;
						used_q[pos] <= 1'b1;
						key_q[pos] <= kmask;
						exp_q[pos] <= r_q.valid_to;
						st_q[pos] <= ST_ACTIVE;
					end
				end
				CMD_SET_ST: if (hit_q && r_q.new_status != ST_UNKNOWN)
					st_q[hit_idx_q] <= r_q.new_status;
				CMD_REMOVE: if (hit_q) begin
					used_q[hit_idx_q] <= 1'b0;
					key_q[hit_idx_q] <= '0;
					exp_q[hit_idx_q] <= '0;
					st_q[hit_idx_q] <= ST_UNKNOWN;
					if (live_q != '0) live_q <= live_q - 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			hit_idx_q <= '0;
			free_idx_q <= '0;
		end else if (cmd.scan_start) begin
			idx_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.scan_step) begin
			if (!stat.scan_last) idx_q <= idx_q + 1'b1;
			if (!hit_q && match) begin
				hit_q <= 1'b1;
				hit_idx_q <= idx_q;
			end
			if (!free_q && !used_q[idx_q]) begin
				free_q <= 1'b1;
				free_idx_q <= idx_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) r_q <= req;
	end

	always_comb begin
		res_d = '0;
		res_d.live_entries = 5'(live_q);
		case (r_q.cmd)
			CMD_CLEAR: res_d.live_entries = '0;
			CMD_ADD, CMD_ADD_VER: begin
				if (r_q.cmd == CMD_ADD_VER && r_q.valid_to <= r_q.now_secs)
					res_d.error_code = ERR_EXPIRED;
				else if ((r_q.cmd == CMD_ADD_VER && !r_q.signature_ok) || !r_q.digest_ok)
					res_d.error_code = ERR_MAC;
				else if (!hit_q && !free_q)
					res_d.error_code = ERR_FULL;
				else begin
					res_d.error_code = ERR_NONE;
					res_d.slot = 4'(pos);
					res_d.entry_state = ST_ACTIVE;
					if (!hit_q) res_d.live_entries = 5'(live_q + 1'b1);
				end
			end
			CMD_FIND_ACT: if (hit_q && pst == ST_ACTIVE) begin
				res_d.found = 1'b1;
				res_d.slot = 4'(hit_idx_q);
				res_d.entry_state = pst;
			end
			CMD_FIND_ANY: if (hit_q) begin
				res_d.found = 1'b1;
				res_d.slot = 4'(hit_idx_q);
				res_d.entry_state = pst;
			end
			CMD_GET_ST: if (hit_q) begin
				res_d.found = 1'b1;
				res_d.slot = 4'(hit_idx_q);
				res_d.entry_state = (pst == ST_ACTIVE && exp_q[hit_idx_q] <= r_q.now_secs)
					? ST_EXPIRED : pst;
			end
			CMD_SET_ST: if (hit_q && r_q.new_status != ST_UNKNOWN) begin
				res_d.found = 1'b1;
				res_d.slot = 4'(hit_idx_q);
				res_d.entry_state = r_q.new_status;
			end
			CMD_REMOVE: if (hit_q) begin
				res_d.found = 1'b1;
				res_d.slot = 4'(hit_idx_q);
				if (live_q != '0) res_d.live_entries = 5'(live_q - 1'b1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) res_q <= res_d;
	end
endmodule
`default_nettype wire
